[src/srd_pkg.sv]
// shared types and constants for the stillness risk detector
// no dependencies; imported by the top level and the testbench

package srd_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned TickBits   = 16;
  localparam int unsigned ThreshBits = 13;
  localparam int unsigned CfgIdxBits = 8;
  localparam int unsigned CfgBits    = 16;

  localparam logic [ThreshBits-1:0] RiskThresholdReset = 13'd100;
  localparam logic [TickBits-1:0]   PressMinReset      = 16'd1498;
  localparam logic [TickBits-1:0]   PressMaxReset      = 16'd3500;
  localparam logic [TickBits-1:0]   CounterTopReset    = 16'd19999;

  typedef enum logic [1:0] {
    FuncSample   = 2'd0,
    FuncOverflow = 2'd1,
    FuncRise     = 2'd2,
    FuncFall     = 2'd3
  } srd_func_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgRiskThreshold = 8'd0,
    CfgPressMin      = 8'd1,
    CfgPressMax      = 8'd2,
    CfgCounterTop    = 8'd3
  } srd_cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StSweep,
    StWrap,
    StEval,
    StLen,
    StCmp,
    StPub
  } srd_state_e;

  typedef struct packed {
    srd_func_e             func;
    logic [SampleBits-1:0] sample;
    logic [TickBits-1:0]   capture;
  } srd_in_t;

  typedef struct packed {
    logic                  risk;
    logic                  system_active;
    logic [SampleBits-1:0] window_max_diff;
  } srd_out_t;

endpackage

[src/srd_ram.sv]
// generic single write port ram with registered read
// no dependencies

module srd_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/stillness_risk_detector.sv]
// top level of the stillness risk detector
// depends on srd_pkg and srd_ram

// Every input transaction is one event chosen by func and yields exactly one
// output transaction carrying risk, system_active and window_max_diff. Sensor
// samples are decimated by DECIMATION; each kept sample is written into a
// WINDOW_DEPTH-entry ring held in a single-port-read ram, then the ring is
// swept one entry per cycle through the ram read port to find the largest
// circular adjacent difference, which is compared against risk_threshold.
// Steps, from accepting an event to being ready for the next one with the
// output register free: a kept sample runs the ring sweep, the wrap-around
// pair, evaluation and publish; a falling button edge passes a registered
// 16x16 multiply, length sum, limit compare and publish; other events only
// publish. A new event is taken once the previous result sits in the output
// register, so a stalled consumer only holds off the block when a second
// result would need the register. Turning the system on empties the ring
// through per-entry valid flags, so no clearing pass is needed and reads of
// emptied entries give zero. Configuration writes are always accepted
// (cfg_ready_o is tied high) and must only be issued while the block is idle.

module stillness_risk_detector #(
  parameter int unsigned WINDOW_DEPTH = 15,
  parameter int unsigned DECIMATION   = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // event channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  srd_pkg::srd_in_t                   in_data_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output srd_pkg::srd_out_t                  out_data_o,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [srd_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [srd_pkg::CfgBits-1:0]        cfg_data_i
);

  import srd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned DW = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0] SweepEnd = CW'(WINDOW_DEPTH);
  localparam logic [DW-1:0] DecLast = DW'(DECIMATION - 1);

  // configuration registers
  logic [ThreshBits-1:0] risk_threshold_q;
  logic [TickBits-1:0]   press_min_q, press_max_q, counter_top_q;

  // control state
  srd_state_e            state_q, state_d;
  logic [AW-1:0]         ring_idx_q;
  logic [DW-1:0]         dec_cnt_q;
  logic                  active_q;
  logic                  risk_q;
  logic [TickBits-1:0]   ovf_cnt_q;
  logic [TickBits-1:0]   press_start_q;
  logic [SampleBits-1:0] last_max_q;
  logic [WINDOW_DEPTH-1:0] entry_vld_q;

  // sweep control
  logic [CW-1:0]         sweep_addr_q;
  logic                  rd_pend_q;
  logic [AW-1:0]         rd_idx_q;
  logic                  rd_vld_q;

  // sweep datapath
  logic [SampleBits-1:0] first_q, prev_q, max_q;
  logic [SampleBits-1:0] rd_data, cur_smp, gap_a, gap;

  // press length datapath
  logic [2*TickBits-1:0] prod_q, len_q;
  logic [TickBits-1:0]   cap_q;

  // result register
  logic                  out_valid_q;
  srd_out_t              out_q;

  logic in_acc, out_free, keep_smp, do_toggle, sweep_done;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && (state_q == StIdle);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign keep_smp    = (dec_cnt_q == DecLast);
  assign do_toggle   = (len_q > {{TickBits{1'b0}}, press_min_q}) &&
                       (len_q < {{TickBits{1'b0}}, press_max_q});
  assign sweep_done  = rd_pend_q && (rd_idx_q == LastIdx);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ring store, written straight from the accepted sample when it is kept
  srd_ram #(
    .WIDTH (SampleBits),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_data_i.func == FuncSample) && keep_smp),
    .waddr_i (ring_idx_q),
    .wdata_i (in_data_i.sample),
    .raddr_i (sweep_addr_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  // emptied entries read as zero
  assign cur_smp = rd_vld_q ? rd_data : '0;
  // wrap-around pair compares the last entry with the first
  assign gap_a   = (state_q == StWrap) ? first_q : cur_smp;
  assign gap     = (gap_a > prev_q) ? (gap_a - prev_q) : (prev_q - gap_a);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          unique case (in_data_i.func)
            FuncSample:   state_d = keep_smp ? StSweep : StPub;
            FuncOverflow: state_d = StPub;
            FuncRise:     state_d = StPub;
            FuncFall:     state_d = StLen;
          endcase
        end
      end
      StSweep: if (sweep_done) state_d = StWrap;
      StWrap:  state_d = StEval;
      StEval:  state_d = StPub;
      StLen:   state_d = StCmp;
      StCmp:   state_d = StPub;
      StPub:   if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      risk_threshold_q <= RiskThresholdReset;
      press_min_q      <= PressMinReset;
      press_max_q      <= PressMaxReset;
      counter_top_q    <= CounterTopReset;
    end else if (cfg_valid_i) begin
      priority case (cfg_index_i)
        CfgRiskThreshold: risk_threshold_q <= cfg_data_i[ThreshBits-1:0];
        CfgPressMin:      press_min_q      <= cfg_data_i;
        CfgPressMax:      press_max_q      <= cfg_data_i;
        CfgCounterTop:    counter_top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // event state, ring bookkeeping and system toggle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_idx_q    <= '0;
      dec_cnt_q     <= '0;
      active_q      <= 1'b0;
      risk_q        <= 1'b0;
      ovf_cnt_q     <= '0;
      press_start_q <= '0;
      last_max_q    <= '0;
      entry_vld_q   <= '0;
    end else begin
      if (in_acc) begin
        unique case (in_data_i.func)
          FuncSample: begin
            if (keep_smp) begin
              entry_vld_q[ring_idx_q] <= 1'b1;
              ring_idx_q <= (ring_idx_q == LastIdx) ? '0 : ring_idx_q + 1'b1;
              dec_cnt_q  <= '0;
            end else begin
              dec_cnt_q <= dec_cnt_q + 1'b1;
            end
          end
          FuncOverflow: begin
            // saturating count
            if (ovf_cnt_q != '1) ovf_cnt_q <= ovf_cnt_q + 1'b1;
          end
          FuncRise: begin
            press_start_q <= in_data_i.capture;
            ovf_cnt_q     <= '0;
          end
          FuncFall: begin
            ovf_cnt_q <= '0;
          end
        endcase
      end
      if (state_q == StEval) begin
        last_max_q <= max_q;
        risk_q     <= ({1'b0, max_q} < risk_threshold_q) && active_q;
      end
      if ((state_q == StCmp) && do_toggle) begin
        if (!active_q) begin
          // switching on empties the ring
          active_q    <= 1'b1;
          entry_vld_q <= '0;
          ring_idx_q  <= '0;
        end else begin
          active_q <= 1'b0;
          risk_q   <= 1'b0;
        end
      end
    end
  end

  // sweep read issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_addr_q <= '0;
      rd_pend_q    <= 1'b0;
      rd_idx_q     <= '0;
      rd_vld_q     <= 1'b0;
    end else begin
      rd_pend_q <= (state_q == StSweep) && (sweep_addr_q != SweepEnd);
      if (state_q == StIdle) begin
        sweep_addr_q <= '0;
      end else if ((state_q == StSweep) && (sweep_addr_q != SweepEnd)) begin
        sweep_addr_q <= sweep_addr_q + 1'b1;
        rd_idx_q     <= sweep_addr_q[AW-1:0];
        rd_vld_q     <= entry_vld_q[sweep_addr_q[AW-1:0]];
      end
    end
  end

  // sweep running maximum
  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      prev_q <= cur_smp;
      if (rd_idx_q == '0) begin
        first_q <= cur_smp;
        max_q   <= '0;
      end else if (gap > max_q) begin
        max_q <= gap;
      end
    end else if ((state_q == StWrap) && (gap > max_q)) begin
      max_q <= gap;
    end
  end

  // press length: product at accept, then the modulo 2^32 sum
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_data_i.func == FuncFall)) begin
      prod_q <= {{TickBits{1'b0}}, ovf_cnt_q} * {{TickBits{1'b0}}, counter_top_q};
      cap_q  <= in_data_i.capture;
    end
    if (state_q == StLen) begin
      len_q <= prod_q - {{TickBits{1'b0}}, press_start_q} + {{TickBits{1'b0}}, cap_q};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == StPub) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StPub) && out_free) begin
      out_q.risk            <= risk_q;
      out_q.system_active   <= active_q;
      out_q.window_max_diff <= last_max_q;
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for stillness_risk_detector: directed and random events
// against an in-bench model of the sample ring, press timing and risk flag
// depends on srd_pkg and the detector rtl

module testbench;
  import srd_pkg::*;

  localparam int unsigned RingDepth    = 15;
  localparam int unsigned KeepEvery    = 3;
  // covers the sweep of a kept sample and any other tail
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned ReportCap    = 100;

  // ---------------------------------------------------------------------------
  // clock, reset and bench-side signals, all known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  ev_valid  = 1'b0;
  logic                  ev_stall;
  srd_in_t               ev_data   = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  srd_out_t              res_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [CfgBits-1:0]    cfg_data  = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stillness_risk_detector dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (ev_valid),
    .in_stall_o  (ev_stall),
    .in_data_i   (ev_data),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  srd_in_t     event_backlog[$];    // events waiting for the driver
  srd_out_t    status_expected[$];  // predicted results, oldest first
  int unsigned events_queued = 0;
  int unsigned events_taken  = 0;
  int unsigned results_seen  = 0;
  int unsigned risk_results  = 0;
  int unsigned toggles       = 0;
  int unsigned failures      = 0;

  // idling control: calm stretches have no gaps or stalls
  logic        calm       = 1'b0;
  int unsigned calm_left  = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  logic        ev_taken   = 1'b0;

  // ---------------------------------------------------------------------------
  // detector model: configuration copy and state
  // ---------------------------------------------------------------------------
  logic [ThreshBits-1:0] thr_lvl  = RiskThresholdReset;
  logic [TickBits-1:0]   lim_min  = PressMinReset;
  logic [TickBits-1:0]   lim_max  = PressMaxReset;
  logic [TickBits-1:0]   tick_top = CounterTopReset;

  logic [SampleBits-1:0] win_sample [RingDepth];
  logic [3:0]            win_wr     = '0;
  logic [1:0]            keep_count = '0;
  logic                  sys_on     = 1'b0;
  logic                  risk_lvl   = 1'b0;
  logic [TickBits-1:0]   ovf_ticks  = '0;
  logic [TickBits-1:0]   press_t0   = '0;
  logic [SampleBits-1:0] spread_now = '0;

  task automatic clear_window();
    foreach (win_sample[k]) win_sample[k] = '0;
    win_wr = '0;
  endtask

  initial clear_window();

  function automatic logic [SampleBits-1:0] gap_of(input logic [SampleBits-1:0] a,
                                                   input logic [SampleBits-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // largest difference between neighbours, last entry wrapping to the first
  function automatic logic [SampleBits-1:0] window_spread();
    logic [SampleBits-1:0] best;
    logic [SampleBits-1:0] step;
    best = gap_of(win_sample[0], win_sample[RingDepth-1]);
    for (int unsigned k = 1; k < RingDepth; k++) begin
      step = gap_of(win_sample[k], win_sample[k-1]);
      if (step > best) best = step;
    end
    return best;
  endfunction

  task automatic apply_cfg(input logic [CfgIdxBits-1:0] idx, input logic [CfgBits-1:0] val);
    case (srd_cfg_idx_e'(idx))
      CfgRiskThreshold: thr_lvl  = val[ThreshBits-1:0];
      CfgPressMin:      lim_min  = val;
      CfgPressMax:      lim_max  = val;
      CfgCounterTop:    tick_top = val;
      default: ;
    endcase
  endtask

  // one event in, one status out
  task automatic advance_detector(input srd_in_t ev, output srd_out_t res);
    logic [31:0] press_len;
    case (ev.func)
      FuncSample: begin
        if (keep_count < 2'(KeepEvery - 1)) begin
          keep_count = keep_count + 2'd1;
        end else begin
          win_sample[win_wr] = ev.sample;
          win_wr     = (win_wr == 4'(RingDepth - 1)) ? 4'd0 : win_wr + 4'd1;
          keep_count = '0;
          spread_now = window_spread();
          // evaluated whether on or off, but only raised while on
          risk_lvl   = sys_on && ({1'b0, spread_now} < thr_lvl);
        end
      end
      FuncOverflow: begin
        if (ovf_ticks != '1) ovf_ticks = ovf_ticks + 16'd1;
      end
      FuncRise: begin
        press_t0  = ev.capture;
        ovf_ticks = '0;
      end
      default: begin
        // press length wraps in 32 bits, so an early release looks huge
        press_len = 32'(ovf_ticks) * 32'(tick_top) - 32'(press_t0) + 32'(ev.capture);
        ovf_ticks = '0;
        if (press_len > 32'(lim_min) && press_len < 32'(lim_max)) begin
          toggles++;
          if (!sys_on) begin
            sys_on = 1'b1;
            clear_window();
          end else begin
            sys_on   = 1'b0;
            risk_lvl = 1'b0;
          end
        end
      end
    endcase
    res.risk            = risk_lvl;
    res.system_active   = sys_on;
    res.window_max_diff = spread_now;
  endtask

  // ---------------------------------------------------------------------------
  // idling
  // ---------------------------------------------------------------------------
  // mostly short runs, now and then a long one
  function automatic int unsigned idle_run();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
  endfunction

  // alternate busy stretches with calm ones that have no gaps or stalls at all
  always @(posedge clk) begin
    if (calm_left != 0) begin
      calm_left--;
    end else begin
      calm      <= !calm;
      calm_left = calm ? $urandom_range(200, 600) : $urandom_range(60, 200);
    end
  end

  // result side back-pressure, changed on the falling edge
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (calm) begin
      res_stall <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      res_stall  <= 1'b1;
      stall_left = idle_run();
    end else begin
      res_stall  <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end
  end

  // ---------------------------------------------------------------------------
  // event driver: holds a transaction until taken, then an optional gap
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      ev_valid <= 1'b0;
    end else if (!ev_valid || ev_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        ev_valid <= 1'b0;
      end else if (event_backlog.size() != 0) begin
        ev_data  <= event_backlog.pop_front();
        ev_valid <= 1'b1;
        gap_left = (calm || $urandom_range(0, 2) != 0) ? 0 : idle_run();
      end else begin
        ev_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks results, tracks register writes, predicts taken events
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    srd_out_t got;
    srd_out_t want;
    srd_out_t fresh;
    ev_taken <= ev_valid && !ev_stall;
    if (rst_n) begin
      // a result at this edge always belongs to an earlier event
      if (res_valid && !res_stall) begin
        got = res_data;
        results_seen++;
        if (got.risk) risk_results++;
        if (status_expected.size() == 0) begin
          failures++;
          if (failures <= ReportCap)
            $display("%0t: result with nothing outstanding: risk=%0b active=%0b diff=%0d",
                     $time, got.risk, got.system_active, got.window_max_diff);
        end else begin
          want = status_expected.pop_front();
          if (got.risk !== want.risk || got.system_active !== want.system_active ||
              got.window_max_diff !== want.window_max_diff) begin
            failures++;
            if (failures <= ReportCap)
              $display("%0t: expected risk=%0b active=%0b diff=%0d, actual risk=%0b %s%0d",
                       $time, want.risk, want.system_active, want.window_max_diff,
                       got.risk, $sformatf("active=%0b diff=", got.system_active),
                       got.window_max_diff);
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (ev_valid && !ev_stall) begin
        advance_detector(ev_data, fresh);
        status_expected.push_back(fresh);
        events_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic post(input srd_func_e f, input logic [SampleBits-1:0] s,
                      input logic [TickBits-1:0] c);
    srd_in_t ev;
    ev.func    = f;
    ev.sample  = s;
    ev.capture = c;
    event_backlog.push_back(ev);
    events_queued++;
  endtask

  // rise, a few overflows, fall; well formed means the length lands inside the limits
  task automatic queue_press(input bit well_formed);
    int unsigned n;
    int unsigned len;
    longint      base;
    longint      lo;
    longint      hi;
    longint      c1;
    longint      c2;
    n = $urandom_range(0, 2);
    if (well_formed && int'(lim_max) > int'(lim_min) + 1)
      len = $urandom_range(int'(lim_min) + 1, int'(lim_max) - 1);
    else
      len = $urandom_range(0, 70000);
    // fall capture = rise capture - base, both must fit in 16 bits
    base = longint'(n) * longint'(tick_top) - longint'(len);
    lo   = (base > 0) ? base : 0;
    hi   = (base < 0) ? base + 65535 : 65535;
    if (lo > hi) begin
      c1 = $urandom_range(0, 65535);
      c2 = $urandom_range(0, 65535);
    end else begin
      c1 = lo + $urandom_range(0, 32'(hi - lo));
      c2 = c1 - base;
    end
    post(FuncRise, SampleBits'($urandom), TickBits'(c1));
    repeat (n) begin
      post(FuncOverflow, SampleBits'($urandom), TickBits'($urandom));
      if ($urandom_range(0, 3) == 0) post(FuncSample, SampleBits'($urandom), TickBits'($urandom));
    end
    post(FuncFall, SampleBits'($urandom), TickBits'(c2));
  endtask

  // random traffic: sample bursts with steady or jumpy content, presses and noise
  task automatic queue_mix(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned burst;
    int unsigned jitter;
    int unsigned level;
    stop_at = events_queued + count;
    while (events_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        burst = $urandom_range(3, 30);
        level = $urandom_range(0, 4095);
        case ($urandom_range(0, 4))
          0:       jitter = 0;
          1:       jitter = 3;
          2:       jitter = 60;
          3:       jitter = 400;
          default: jitter = 4095;
        endcase
        repeat (burst)
          post(FuncSample, SampleBits'(level + $urandom_range(0, jitter)), TickBits'($urandom));
      end else if (pick < 70) begin
        queue_press(1'b1);
      end else if (pick < 78) begin
        queue_press(1'b0);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 5))
          post(FuncOverflow, SampleBits'($urandom), TickBits'($urandom));
      end else begin
        post(srd_func_e'($urandom_range(0, 3)), SampleBits'($urandom), TickBits'($urandom));
      end
    end
  endtask

  // every taken transaction answered, then let the block settle
  task automatic wait_idle();
    while (events_taken != events_queued || status_expected.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_cfg(input srd_cfg_idx_e idx, input logic [CfgBits-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [CfgBits-1:0] thr, input logic [CfgBits-1:0] pmin,
                           input logic [CfgBits-1:0] pmax, input logic [CfgBits-1:0] top);
    wait_idle();
    write_cfg(CfgRiskThreshold, thr);
    write_cfg(CfgPressMin, pmin);
    write_cfg(CfgPressMax, pmax);
    write_cfg(CfgCounterTop, top);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pmin_r;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part with reset limits: decimation, short, long and wrapped
    // presses, switching on with an emptied ring, switching off with risk cleared
    post(FuncSample,   12'hFFF, 16'h0000);
    post(FuncSample,   12'h000, 16'hFFFF);
    post(FuncSample,   12'hFFF, 16'h0000);
    post(FuncOverflow, 12'h000, 16'hFFFF);
    post(FuncRise,     12'hFFF, 16'hFFFF);
    post(FuncOverflow, 12'h000, 16'h0000);
    post(FuncFall,     12'hFFF, 16'h0000);   // length wraps negative, no toggle
    post(FuncRise,     12'h000, 16'h1234);
    post(FuncFall,     12'h000, 16'h1234 + 16'd1498);   // equal to lower limit
    post(FuncRise,     12'hAAA, 16'h0000);
    post(FuncFall,     12'h555, 16'd3500);              // equal to upper limit
    post(FuncRise,     12'h555, 16'hAAAA);
    post(FuncFall,     12'hAAA, 16'hAAAA + 16'd2000);   // switches on
    post(FuncSample,   12'h555, 16'h5555);
    post(FuncSample,   12'hAAA, 16'hAAAA);
    post(FuncSample,   12'd50,  16'h0000);              // kept, small spread: risk
    post(FuncRise,     12'h000, 16'hFFFF);
    post(FuncOverflow, 12'hFFF, 16'h0000);
    post(FuncFall,     12'h000, 16'd48036);             // one overflow, switches off
    post(FuncFall,     12'hFFF, 16'h0001);              // release with no press
    post(FuncSample,   12'h000, 16'h5555);
    post(FuncSample,   12'h000, 16'hAAAA);
    post(FuncSample,   12'hFFF, 16'hFFFF);
    post(FuncOverflow, 12'h555, 16'h1234);

    // random phases across the register extremes
    configure(16'd4096, 16'd0, 16'hFFFF, 16'd0);
    queue_mix(200);
    configure(16'd0, PressMinReset, PressMaxReset, 16'hFFFF);
    queue_mix(200);
    configure(16'hFFFF, 16'hFFFF, 16'd0, 16'd1);        // nothing can toggle
    queue_mix(100);
    pmin_r = $urandom_range(0, 30000);
    configure(CfgBits'($urandom_range(0, 4096)), CfgBits'(pmin_r),
              CfgBits'(pmin_r + $urandom_range(2, 30000)), CfgBits'($urandom));
    queue_mix(250);
    configure(16'(RiskThresholdReset), PressMinReset, PressMaxReset, CounterTopReset);
    queue_mix(300);
    wait_idle();

    $display("%0d events driven, %0d results checked, %0d on/off toggles, %0d with risk set",
             events_taken, results_seen, toggles, risk_results);
    if (failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // hang guard, well beyond the slowest legitimate run
  initial begin
    #(10_000_000);
    $display("timeout with %0d results still outstanding", status_expected.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
src/srd_pkg.sv
src/srd_ram.sv
src/stillness_risk_detector.sv
tb/testbench.sv
